FILE: hdl/gft_pkg.sv
// Shared types, constants and arithmetic helpers of the goniometer frame transform.
package gft_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int TRIG_STAGES_DEF = 24;
   localparam int OFFSET_Z_MM     = 18;

   // CORDIC start value (gain compensated) and unity, Q30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

   typedef enum logic [1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2
   } csr_index_type;

   // one rotation lane of the CORDIC chain
   typedef struct packed {
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } lane_type;

   // lane 0 omega, lane 1 chi, lane 2 phi
   typedef lane_type [2:0] lanes_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } pay_type;

   typedef logic [2:0][31:0] offsets_type;

   // arctangent of 2^-i as a binary angle (full turn = 2^32)
   function automatic logic [31:0] atan_bam(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2FA;
         15:      v = 32'h0000517D;
         16:      v = 32'h000028BE;
         17:      v = 32'h0000145F;
         18:      v = 32'h00000A30;
         19:      v = 32'h00000518;
         20:      v = 32'h0000028C;
         21:      v = 32'h00000146;
         22:      v = 32'h000000A3;
         23:      v = 32'h00000051;
         24:      v = 32'h00000029;
         25:      v = 32'h00000014;
         26:      v = 32'h0000000A;
         27:      v = 32'h00000005;
         28:      v = 32'h00000003;
         29:      v = 32'h00000001;
         30:      v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Q30 product, round half up: (a*b + 2^29) >>> 30
   function automatic logic signed [35:0] rmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b);
      p = p + 66'sd536870912;
      return 36'(p >>> 30);
   endfunction

   // clamp to [-1, 1] in Q30
   function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'(Q30_ONE)) begin
         r = 32'(Q30_ONE);
      end else if (v < -36'(Q30_ONE)) begin
         r = -32'(Q30_ONE);
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

FILE: hdl/gft_angle.sv
// Degrees to binary angle conversion and quadrant folding, three stages.
module gft_angle #(
   parameter int FRAC_BITS = gft_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [25:0] angle_i,
   output gft_pkg::lane_type  lane_o
);
   import gft_pkg::*;

   localparam int unsigned Shift    = 29 - FRAC_BITS;
   localparam logic [25:0] Recip45  = 26'd47721859;
   localparam logic [25:0] Step45   = 26'd45;
   localparam int unsigned HalfStep = 22;

   // (r * 2^Shift + HalfStep) / 45 for every remainder r
   logic [31:0] rem_tab [64];
   for (genvar r = 0; r < 64; r++) begin : g_tab
      localparam int unsigned Entry = (r < 45) ? (((r << Shift) + HalfStep) / 45) : 0;
      assign rem_tab[r] = 32'(Entry);
   end

   logic              neg_ff;
   logic [25:0]       mag_in, mag_ff;
   logic [51:0]       prod_w;
   logic [20:0]       qm_ff;
   logic [5:0]        rm_w;
   logic [31:0]       q_w, bam_in, bam_ff;
   logic signed [33:0] z_w;
   lane_type          lane_in, lane_ff;

   // stage 1: magnitude and quotient by 45 through a reciprocal
   assign mag_in = angle_i[25] ? 26'(-angle_i) : 26'(angle_i);
   assign prod_w = 52'(mag_in) * 52'(Recip45);

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= angle_i[25];
         mag_ff <= mag_in;
         qm_ff  <= prod_w[51:31];
      end
   end

   // stage 2: remainder, rounded quotient, sign
   assign rm_w   = 6'(mag_ff - 26'(qm_ff) * Step45);
   assign q_w    = (32'(qm_ff) << Shift) + rem_tab[rm_w];
   assign bam_in = neg_ff ? -q_w : q_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         bam_ff <= bam_in;
      end
   end

   // stage 3: fold into +-90 degrees
   assign z_w = 34'($signed(bam_ff));

   always_comb begin
      lane_in.x    = CORDIC_GAIN;
      lane_in.y    = '0;
      lane_in.z    = z_w;
      lane_in.flip = 1'b0;
      if (z_w > 34'sd1073741824) begin
         lane_in.z    = z_w - 34'sd2147483648;
         lane_in.flip = 1'b1;
      end else if (z_w < -34'sd1073741824) begin
         lane_in.z    = z_w + 34'sd2147483648;
         lane_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

FILE: hdl/gft_cordic_cell.sv
// One CORDIC rotation step for the three angle lanes.
module gft_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic               clock,
   input  logic               adv,
   input  gft_pkg::lanes_type lanes_i,
   output gft_pkg::lanes_type lanes_o
);
   import gft_pkg::*;

   localparam logic signed [33:0] Angle = 34'(atan_bam(STAGE));

   lanes_type lanes_in, lanes_ff;

   // rotate toward zero residual angle
   always_comb begin
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      for (int k = 0; k < 3; k++) begin
         xs = lanes_i[k].x >>> STAGE;
         ys = lanes_i[k].y >>> STAGE;
         lanes_in[k].flip = lanes_i[k].flip;
         if (lanes_i[k].z >= 0) begin
            lanes_in[k].x = lanes_i[k].x - ys;
            lanes_in[k].y = lanes_i[k].y + xs;
            lanes_in[k].z = lanes_i[k].z - Angle;
         end else begin
            lanes_in[k].x = lanes_i[k].x + ys;
            lanes_in[k].y = lanes_i[k].y - xs;
            lanes_in[k].z = lanes_i[k].z + Angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff <= lanes_in;
      end
   end

   assign lanes_o = lanes_ff;

endmodule

FILE: hdl/gft_matrix.sv
// Rotation matrix build and matrix-vector product with offset, six stages.
module gft_matrix (
   input  logic                 clock,
   input  logic                 adv,
   input  gft_pkg::lanes_type   lanes_i,
   input  gft_pkg::pay_type     pay_i,
   input  gft_pkg::offsets_type offsets_i,
   output logic signed [31:0]   out_x,
   output logic signed [31:0]   out_y,
   output logic signed [31:0]   out_z,
   output logic                 saturated
);
   import gft_pkg::*;

   // stage 0: sign flip and clamp of sine and cosine
   logic signed [31:0] cos_in [3];
   logic signed [31:0] sin_in [3];
   logic signed [31:0] cos_ff [3];
   logic signed [31:0] sin_ff [3];
   pay_type            pay0_ff, pay1_ff, pay2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cos_in[k] = clamp_q30(lanes_i[k].flip ? -36'(lanes_i[k].x) : 36'(lanes_i[k].x));
         sin_in[k] = clamp_q30(lanes_i[k].flip ? -36'(lanes_i[k].y) : 36'(lanes_i[k].y));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         pay0_ff <= pay_i;
      end
   end

   logic signed [31:0] so, co, sc, cc, sp, cp;
   assign co = cos_ff[0];
   assign so = sin_ff[0];
   assign cc = cos_ff[1];
   assign sc = sin_ff[1];
   assign cp = cos_ff[2];
   assign sp = sin_ff[2];

   // stage 1: products of two factors
   logic signed [31:0] cc_co_ff, cc_cp_ff, cc_so_ff, so_sp_ff, co_sp_ff, sc_sp_ff;
   logic signed [31:0] cp_so_ff, co_cp_ff, cp_sc_ff, co_sc_ff, sc_so_ff;
   logic signed [31:0] cc1_ff, cp1_ff, so1_ff, sp1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_co_ff <= 32'(rmul(33'(cc), 33'(co)));
         cc_cp_ff <= 32'(rmul(33'(cc), 33'(cp)));
         cc_so_ff <= 32'(rmul(33'(cc), 33'(so)));
         so_sp_ff <= 32'(rmul(33'(so), 33'(sp)));
         co_sp_ff <= 32'(rmul(33'(co), 33'(sp)));
         sc_sp_ff <= 32'(rmul(33'(sc), 33'(sp)));
         cp_so_ff <= 32'(rmul(33'(cp), 33'(so)));
         co_cp_ff <= 32'(rmul(33'(co), 33'(cp)));
         cp_sc_ff <= 32'(rmul(33'(cp), 33'(sc)));
         co_sc_ff <= 32'(rmul(33'(co), 33'(sc)));
         sc_so_ff <= 32'(rmul(33'(sc), 33'(so)));
         cc1_ff   <= cc;
         cp1_ff   <= cp;
         so1_ff   <= so;
         sp1_ff   <= sp;
         pay1_ff  <= pay0_ff;
      end
   end

   // stage 2: three-factor products, pass-through of the rest
   logic signed [31:0] t_cccocp_ff, t_cccpso_ff, t_cccosp_ff, t_ccsosp_ff;
   logic signed [31:0] so_sp2_ff, co_sp2_ff, sc_sp2_ff, cp_so2_ff, co_cp2_ff;
   logic signed [31:0] cp_sc2_ff, co_sc2_ff, sc_so2_ff, cc2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t_cccocp_ff <= 32'(rmul(33'(cc_co_ff), 33'(cp1_ff)));
         t_cccpso_ff <= 32'(rmul(33'(cc_cp_ff), 33'(so1_ff)));
         t_cccosp_ff <= 32'(rmul(33'(cc_co_ff), 33'(sp1_ff)));
         t_ccsosp_ff <= 32'(rmul(33'(cc_so_ff), 33'(sp1_ff)));
         so_sp2_ff   <= so_sp_ff;
         co_sp2_ff   <= co_sp_ff;
         sc_sp2_ff   <= sc_sp_ff;
         cp_so2_ff   <= cp_so_ff;
         co_cp2_ff   <= co_cp_ff;
         cp_sc2_ff   <= cp_sc_ff;
         co_sc2_ff   <= co_sc_ff;
         sc_so2_ff   <= sc_so_ff;
         cc2_ff      <= cc1_ff;
         pay2_ff     <= pay1_ff;
      end
   end

   // stage 3: matrix entries and source vector
   logic signed [31:0] r_in [3][3];
   logic signed [31:0] r_ff [3][3];
   logic signed [32:0] v_in [3];
   logic signed [32:0] v_ff [3];
   logic signed [31:0] pos_w [3];
   logic               mode3_ff;

   assign pos_w[0] = pay2_ff.pos_x;
   assign pos_w[1] = pay2_ff.pos_y;
   assign pos_w[2] = pay2_ff.pos_z;

   always_comb begin
      r_in[0][0] = clamp_q30(36'(cp_sc2_ff));
      r_in[0][1] = clamp_q30(-(36'(so_sp2_ff) + 36'(t_cccocp_ff)));
      r_in[0][2] = clamp_q30(36'(t_cccpso_ff) - 36'(co_sp2_ff));
      r_in[1][0] = clamp_q30(-36'(sc_sp2_ff));
      r_in[1][1] = clamp_q30(36'(t_cccosp_ff) - 36'(cp_so2_ff));
      r_in[1][2] = clamp_q30(-(36'(co_cp2_ff) + 36'(t_ccsosp_ff)));
      r_in[2][0] = clamp_q30(-36'(cc2_ff));
      r_in[2][1] = clamp_q30(-36'(co_sc2_ff));
      r_in[2][2] = clamp_q30(36'(sc_so2_ff));
      for (int j = 0; j < 3; j++) begin
         if (pay2_ff.mode) begin
            v_in[j] = 33'(pos_w[j]) - 33'($signed(offsets_i[j]));
         end else begin
            v_in[j] = 33'(pos_w[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff     <= r_in;
         v_ff     <= v_in;
         mode3_ff <= pay2_ff.mode;
      end
   end

   // stage 4: nine rounded products, transposed matrix for the inverse
   logic signed [35:0] t_in [3][3];
   logic signed [35:0] t_ff [3][3];
   logic               mode4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            t_in[i][j] = rmul(33'(mode3_ff ? r_ff[j][i] : r_ff[i][j]), v_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         mode4_ff <= mode3_ff;
      end
   end

   // stage 5: row sums, offset, saturation
   logic signed [37:0] acc_w [3];
   logic signed [31:0] res_in [3];
   logic signed [31:0] res_ff [3];
   logic               sat_in, sat_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc_w[i] = 38'(t_ff[i][0]) + 38'(t_ff[i][1]) + 38'(t_ff[i][2]);
         if (!mode4_ff) begin
            acc_w[i] = acc_w[i] + 38'($signed(offsets_i[i]));
         end
         if (acc_w[i] > 38'sd2147483647) begin
            res_in[i] = 32'sh7FFFFFFF;
            sat_in    = 1'b1;
         end else if (acc_w[i] < -38'sd2147483648) begin
            res_in[i] = 32'sh80000000;
            sat_in    = 1'b1;
         end else begin
            res_in[i] = 32'(acc_w[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];
   assign saturated = sat_ff;

endmodule

FILE: hdl/goniometer_frame_transform.sv
// Top level of the goniometer frame transform: angle front end, CORDIC chain, matrix back end.
//
//   channel  ports    direction  content
//   request  req_*    in         mode, position, omega/chi/phi angles
//   response rsp_*    out        transformed position, saturation flag
//   csr      csr_*    in         stage offsets x, y, z (write only)
//
// Fully pipelined: one transfer per cycle while the pipeline advances, through
// 3 angle conversion stages, one CORDIC cell per stage and 6 matrix stages.
// The pipeline advances as a whole; it holds while the output register is
// full and rsp_ready is low, and req_ready follows that condition.
// Reset clears the valid bits and loads the offsets (z offset 18 mm).
module goniometer_frame_transform #(
   parameter int FRAC_BITS   = gft_pkg::FRAC_BITS_DEF,
   parameter int TRIG_STAGES = gft_pkg::TRIG_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [25:0] req_angle_omega,
   input  logic signed [25:0] req_angle_chi,
   input  logic signed [25:0] req_angle_phi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import gft_pkg::*;

   localparam int PayDepth = 3 + TRIG_STAGES;
   localparam int Lat      = PayDepth + 6;
   localparam logic [31:0] OffsetZReset = 32'(OFFSET_Z_MM) << FRAC_BITS;

   logic adv;
   logic [Lat-1:0] vld_ff;

   // whole pipe moves unless a result waits at the output
   assign adv       = !vld_ff[Lat-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   // offset registers
   offsets_type off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= OffsetZReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_X: off_ff[0] <= csr_wdata;
            CSR_OFFSET_Y: off_ff[1] <= csr_wdata;
            CSR_OFFSET_Z: off_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload delay line alongside the angle stages and CORDIC cells
   pay_type pay_in;
   pay_type pay_ff [PayDepth];

   assign pay_in.mode  = req_mode;
   assign pay_in.pos_x = req_pos_x;
   assign pay_in.pos_y = req_pos_y;
   assign pay_in.pos_z = req_pos_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0] <= pay_in;
         for (int k = 1; k < PayDepth; k++) begin
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   // angle front end
   lanes_type chain_w [TRIG_STAGES+1];

   gft_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_omega (
      .clock   (clock),
      .adv     (adv),
      .angle_i (req_angle_omega),
      .lane_o  (chain_w[0][0])
   );

   gft_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_chi (
      .clock   (clock),
      .adv     (adv),
      .angle_i (req_angle_chi),
      .lane_o  (chain_w[0][1])
   );

   gft_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_phi (
      .clock   (clock),
      .adv     (adv),
      .angle_i (req_angle_phi),
      .lane_o  (chain_w[0][2])
   );

   // CORDIC cell chain
   for (genvar s = 0; s < TRIG_STAGES; s++) begin : g_cell
      gft_cordic_cell #(.STAGE(s)) u_cell (
         .clock   (clock),
         .adv     (adv),
         .lanes_i (chain_w[s]),
         .lanes_o (chain_w[s+1])
      );
   end

   // matrix build and transform
   gft_matrix u_matrix (
      .clock     (clock),
      .adv       (adv),
      .lanes_i   (chain_w[TRIG_STAGES]),
      .pay_i     (pay_ff[PayDepth-1]),
      .offsets_i (off_ff),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .saturated (rsp_saturated)
   );

endmodule
